FILE: rtl/csv_pkg.sv
// csv_pkg: shared types and constants for the container stream validator
// word structs, byte classes, error codes, magic bytes and register indices; no dependencies

package csv_pkg;

  localparam int unsigned STAGES_PER_TARGET = 10;
  localparam logic [3:0] STAGE_COUNT = 4'(STAGES_PER_TARGET);

  localparam logic [7:0] MAGIC_BYTES [4] = '{8'h4C, 8'h53, 8'h52, 8'h46};

  localparam logic [1:0] REG_FORMAT_VERSION   = 2'd0;
  localparam logic [1:0] REG_CONTRACT_VERSION = 2'd1;
  localparam logic [1:0] REG_TARGET_LIMIT     = 2'd2;

  typedef enum logic [3:0] {
    CLS_MAGIC    = 4'd0,
    CLS_VERSION  = 4'd1,
    CLS_SRC_LEN  = 4'd2,
    CLS_SRC_DATA = 4'd3,
    CLS_COUNT    = 4'd4,
    CLS_TID      = 4'd5,
    CLS_ST_LEN   = 4'd6,
    CLS_ST_DATA  = 4'd7,
    CLS_IGNORED  = 4'd8
  } byte_class_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MAGIC     = 3'd1,
    ERR_VERSION   = 3'd2,
    ERR_CONTRACT  = 3'd3,
    ERR_COUNT     = 3'd4,
    ERR_TARGET    = 3'd5,
    ERR_TRUNCATED = 3'd6,
    ERR_TRAILING  = 3'd7
  } err_code_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_word_t;

  typedef struct packed {
    logic [3:0] byte_class;
    logic [7:0] byte_out;
    logic [3:0] target_now;
    logic [3:0] stage_now;
    logic [2:0] err_code;
    logic       pack_end;
    logic       pack_valid;
  } result_word_t;

endpackage

FILE: rtl/container_stream_validator_core.sv
// container_stream_validator_core: byte-serial layout checker for packed containers
// depends on csv_pkg for word structs, classes and error codes
//
//  channel  | handshake                 | word
//  ---------+---------------------------+---------------------------------------
//  item     | item_valid / item_stall   | item (data_byte, last_byte)
//  result   | result_valid / result_stall| result (class, byte, target, stage...)
//  cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// one byte per cycle while item_stall is low: parse state and the result register update
// at the same edge, so each accepted byte shows its result in the cycle after it is taken
// item_stall rises only while a held result is itself stalled
// rst (synchronous) clears parse state, result_valid and the registers to 1, 1, 3
// cfg_ready is always high; a write lands at once and applies to the next byte

module container_stream_validator_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  csv_pkg::item_word_t   item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output csv_pkg::result_word_t result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  import csv_pkg::*;

  typedef enum logic [3:0] {
    PH_MAGIC, PH_VERSION, PH_CONTRACT, PH_SRCLEN, PH_SRCDATA, PH_COUNT,
    PH_TID, PH_STLEN, PH_STDATA, PH_DONE, PH_ERROR
  } phase_t;

  logic [31:0] format_version;
  logic [31:0] contract_version;
  logic [3:0]  target_limit;

  phase_t      phase, phase_next;
  logic [1:0]  byte_in_word, byte_in_word_next;
  logic [31:0] word_gather, word_gather_next;
  logic [31:0] blob_remaining, blob_remaining_next;
  logic [3:0]  targets_remaining, targets_remaining_next;
  logic [3:0]  current_target, current_target_next;
  logic [3:0]  current_stage, current_stage_next;
  logic [2:0]  sticky_error, sticky_error_next;

  result_word_t result_next;
  logic         accept;

  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;
  assign cfg_ready  = 1'b1;

  always_comb begin
    logic [7:0]  b;
    logic        word_phase;
    logic        word_done;
    logic [31:0] w;
    logic [31:0] blob_dec;
    logic [3:0]  stage_inc;
    logic [3:0]  tnow, snow;
    byte_class_t cls;
    logic [2:0]  fail_code;
    logic        do_fail;

    b          = item.data_byte;
    word_phase = (phase == PH_VERSION) || (phase == PH_CONTRACT) ||
                 (phase == PH_SRCLEN) || (phase == PH_COUNT) ||
                 (phase == PH_TID) || (phase == PH_STLEN);
    w          = word_gather | ({24'b0, b} << {byte_in_word, 3'b000});
    word_done  = word_phase && (byte_in_word == 2'd3);
    blob_dec   = blob_remaining - 32'd1;
    stage_inc  = current_stage + 4'd1;
    tnow       = '0;
    snow       = '0;
    cls        = CLS_IGNORED;
    fail_code  = ERR_NONE;
    do_fail    = 1'b0;

    phase_next             = phase;
    byte_in_word_next      = byte_in_word;
    word_gather_next       = word_gather;
    blob_remaining_next    = blob_remaining;
    targets_remaining_next = targets_remaining;
    current_target_next    = current_target;
    current_stage_next     = current_stage;
    sticky_error_next      = sticky_error;

    if (word_phase) begin
      if (word_done) begin
        word_gather_next  = '0;
        byte_in_word_next = '0;
      end else begin
        word_gather_next  = w;
        byte_in_word_next = byte_in_word + 2'd1;
      end
    end

    unique case (phase)
      PH_MAGIC: begin
        cls = CLS_MAGIC;
        if (b != MAGIC_BYTES[byte_in_word]) begin
          byte_in_word_next = '0;
          do_fail   = 1'b1;
          fail_code = ERR_MAGIC;
        end else if (byte_in_word == 2'd3) begin
          byte_in_word_next = '0;
          phase_next = PH_VERSION;
        end else begin
          byte_in_word_next = byte_in_word + 2'd1;
        end
      end
      PH_VERSION: begin
        cls = CLS_VERSION;
        if (word_done) begin
          if (w != format_version) begin
            do_fail   = 1'b1;
            fail_code = ERR_VERSION;
          end else begin
            phase_next = PH_CONTRACT;
          end
        end
      end
      PH_CONTRACT: begin
        cls = CLS_VERSION;
        if (word_done) begin
          if (w != contract_version) begin
            do_fail   = 1'b1;
            fail_code = ERR_CONTRACT;
          end else begin
            phase_next = PH_SRCLEN;
          end
        end
      end
      PH_SRCLEN: begin
        cls = CLS_SRC_LEN;
        if (word_done) begin
          blob_remaining_next = w;
          phase_next = (w == '0) ? PH_COUNT : PH_SRCDATA;
        end
      end
      PH_SRCDATA: begin
        cls = CLS_SRC_DATA;
        blob_remaining_next = blob_dec;
        if (blob_dec == '0) begin
          phase_next = PH_COUNT;
        end
      end
      PH_COUNT: begin
        cls = CLS_COUNT;
        if (word_done) begin
          if (w > {28'b0, target_limit}) begin
            do_fail   = 1'b1;
            fail_code = ERR_COUNT;
          end else begin
            targets_remaining_next = w[3:0];
            phase_next = (w == '0) ? PH_DONE : PH_TID;
          end
        end
      end
      PH_TID: begin
        cls = CLS_TID;
        if (word_done) begin
          if (w >= {28'b0, target_limit}) begin
            do_fail   = 1'b1;
            fail_code = ERR_TARGET;
          end else begin
            current_target_next = w[3:0];
            current_stage_next  = '0;
            phase_next = PH_STLEN;
          end
        end
      end
      PH_STLEN, PH_STDATA: begin
        tnow = current_target;
        snow = current_stage;
        if (phase == PH_STLEN) begin
          cls = CLS_ST_LEN;
          if (word_done) begin
            blob_remaining_next = w;
          end
        end else begin
          cls = CLS_ST_DATA;
          blob_remaining_next = blob_dec;
        end
        if (phase == PH_STLEN && word_done && w != '0) begin
          phase_next = PH_STDATA;
        end else if ((phase == PH_STLEN && word_done) ||
                     (phase == PH_STDATA && blob_dec == '0)) begin
          // stage blob finished
          if (stage_inc >= STAGE_COUNT) begin
            current_stage_next     = '0;
            targets_remaining_next = targets_remaining - 4'd1;
            phase_next = (targets_remaining == 4'd1) ? PH_DONE : PH_TID;
          end else begin
            current_stage_next = stage_inc;
            phase_next = PH_STLEN;
          end
        end
      end
      PH_DONE: begin
        cls       = CLS_IGNORED;
        do_fail   = 1'b1;
        fail_code = ERR_TRAILING;
      end
      default: begin
        cls = CLS_IGNORED;
      end
    endcase

    if (do_fail) begin
      if (sticky_error == ERR_NONE) begin
        sticky_error_next = fail_code;
      end
      phase_next = PH_ERROR;
    end

    if (item.last_byte && sticky_error_next == ERR_NONE && phase_next != PH_DONE) begin
      sticky_error_next = ERR_TRUNCATED;
      phase_next = PH_ERROR;
    end

    result_next.byte_class = cls;
    result_next.byte_out   = b;
    result_next.target_now = tnow;
    result_next.stage_now  = snow;
    result_next.err_code   = sticky_error_next;
    result_next.pack_end   = item.last_byte;
    result_next.pack_valid = item.last_byte && (sticky_error_next == ERR_NONE);

    if (item.last_byte) begin
      phase_next             = PH_MAGIC;
      byte_in_word_next      = '0;
      word_gather_next       = '0;
      blob_remaining_next    = '0;
      targets_remaining_next = '0;
      current_target_next    = '0;
      current_stage_next     = '0;
      sticky_error_next      = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      format_version    <= 32'd1;
      contract_version  <= 32'd1;
      target_limit      <= 4'd3;
      phase             <= PH_MAGIC;
      byte_in_word      <= '0;
      word_gather       <= '0;
      blob_remaining    <= '0;
      targets_remaining <= '0;
      current_target    <= '0;
      current_stage     <= '0;
      sticky_error      <= ERR_NONE;
      result_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_FORMAT_VERSION:   format_version   <= cfg_data;
          REG_CONTRACT_VERSION: contract_version <= cfg_data;
          REG_TARGET_LIMIT:     target_limit     <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase             <= phase_next;
        byte_in_word      <= byte_in_word_next;
        word_gather       <= word_gather_next;
        blob_remaining    <= blob_remaining_next;
        targets_remaining <= targets_remaining_next;
        current_target    <= current_target_next;
        current_stage     <= current_stage_next;
        sticky_error      <= sticky_error_next;
        result_valid      <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule
